// ===== sv/fbsr_pkg.sv =====
package fbsr_pkg;

   // stored frame markers
   localparam logic [7:0] MK_FLAG  = 8'hD0;
   localparam logic [7:0] MK_START = 8'hD1;
   localparam logic [7:0] MK_END   = 8'hD2;

   // request modes
   localparam logic [1:0] MODE_PUSH = 2'd0;
   localparam logic [1:0] MODE_POP  = 2'd1;
   localparam logic [1:0] MODE_PEEK = 2'd2;

   // response status codes
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_FULL    = 2'd1;
   localparam logic [1:0] STAT_NOFRAME = 2'd2;
   localparam logic [1:0] STAT_CORRUPT = 2'd3;

   // field widths
   localparam int CAP_W = 7;
   localparam int LEN_W = 10;
   localparam logic [LEN_W-1:0] LEN_SAT = '1;

   // default sizes
   localparam int DEF_BUF_DEPTH     = 1024;
   localparam int DEF_MAX_POP_BYTES = 64;

endpackage

// ===== sv/framed_byte_stuffed_ring_fifo.sv =====
// Byte ring buffer holding whole frames, stored byte-stuffed between start
// and end markers.
// Request channel (req_*): one transaction per push byte, pop or peek.
// Response channel (rsp_*): a push, peek or idle mode gives one response;
// a pop gives one response per delivered byte (or a single status-only
// response), all carrying the delivered count, the final one marked last.
// A push makes one tentative ring write per stored byte (up to four), then a
// finishing step that commits or rolls back at the frame end. A pop or peek
// walks the stored frame through the ring memory, reading and then examining
// each stored byte, since every ring read is registered; delivered bytes then
// leave the pop buffer one at a time. One request is in flight at a time.
// Reset clears the pointers and flags; the ring is empty afterwards and
// requests are taken at once. Ring slots outside the used span are never
// examined before they are written, so the ring itself needs no clearing.
// While a response is pending and rsp_stall is high, the response register
// holds its value and no further request is taken.
module framed_byte_stuffed_ring_fifo
   import fbsr_pkg::*;
#(
   parameter int BUF_DEPTH     = DEF_BUF_DEPTH,
   parameter int MAX_POP_BYTES = DEF_MAX_POP_BYTES
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [1:0]       req_mode,
   input  logic [7:0]       req_data_byte,
   input  logic             req_frame_last,
   input  logic [CAP_W-1:0] req_capacity,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_byte_valid,
   output logic             rsp_last,
   output logic [1:0]       rsp_status,
   output logic [LEN_W-1:0] rsp_length
);

   localparam int PW = $clog2(BUF_DEPTH);
   localparam int GW = $clog2(MAX_POP_BYTES + 1);
   localparam int BW = (MAX_POP_BYTES > 1) ? $clog2(MAX_POP_BYTES) : 1;
   localparam logic [PW-1:0] LAST_SLOT = PW'(BUF_DEPTH - 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_PUSH, ST_PFIN, ST_SKIP_RD, ST_SKIP_CHK, ST_BODY_RD,
      ST_BODY_CHK, ST_DONE, ST_EMIT_RD, ST_EMIT_LD, ST_EMIT_WAIT, ST_RESP
   } state_type;

   function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
      return (p == LAST_SLOT) ? '0 : p + 1'b1;
   endfunction

   state_type        state_ff;
   logic [PW-1:0]    rp_ff, wp_ff, fsp_ff, tp_ff, p_ff, start_ff;
   logic             pip_ff, ovf_ff, fl_ff, consume_ff, flag_ff;
   logic [7:0]       wq_ff [4];
   logic [2:0]       wn_ff, wi_ff;
   logic [GW-1:0]    cap_ff, got_ff, k_ff;
   logic [LEN_W-1:0] total_ff;
   logic [1:0]       st_ff;

   logic [7:0]       ring_mem [BUF_DEPTH];
   logic [7:0]       ring_q_ff;
   logic [7:0]       buf_mem [2**BW];
   logic [7:0]       buf_q_ff;

   logic             req_take;
   logic             ring_we;
   logic             buf_we;
   logic [7:0]       body_byte;
   logic             body_data;
   logic [7:0]       wq_in [4];
   logic [2:0]       wn_in;
   logic             stuff;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;

   // stored byte sequence for one push transaction
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         wq_in[i] = MK_END;
      end
      wn_in = '0;
      stuff = (req_data_byte == MK_FLAG) || (req_data_byte == MK_START) ||
              (req_data_byte == MK_END);
      if (!pip_ff) begin
         wq_in[0] = MK_START;
         wn_in    = 3'd1;
      end
      if (stuff) begin
         wq_in[wn_in[1:0]]        = MK_FLAG;
         wq_in[wn_in[1:0] + 2'd1] = req_data_byte - MK_FLAG;
         wn_in                    = wn_in + 3'd2;
      end else begin
         wq_in[wn_in[1:0]] = req_data_byte;
         wn_in             = wn_in + 3'd1;
      end
      if (req_frame_last) begin
         wq_in[wn_in[1:0]] = MK_END;
         wn_in             = wn_in + 3'd1;
      end
   end

   // memory write strobes
   always_comb begin
      ring_we   = (state_ff == ST_PUSH) && !ovf_ff && (nxt(tp_ff) != rp_ff);
      body_data = flag_ff || ((ring_q_ff != MK_END) && (ring_q_ff != MK_FLAG));
      body_byte = flag_ff ? (MK_FLAG + ring_q_ff) : ring_q_ff;
      buf_we    = (state_ff == ST_BODY_CHK) && body_data && consume_ff &&
                  (got_ff < cap_ff);
   end

   // ring memory
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[tp_ff] <= wq_ff[wi_ff[1:0]];
      end
      ring_q_ff <= ring_mem[p_ff];
   end

   // pop delivery buffer
   always_ff @(posedge clock) begin
      if (buf_we) begin
         buf_mem[got_ff[BW-1:0]] <= body_byte;
      end
      buf_q_ff <= buf_mem[k_ff[BW-1:0]];
   end

   // control sequencer and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rp_ff     <= '0;
         wp_ff     <= '0;
         fsp_ff    <= '0;
         tp_ff     <= '0;
         pip_ff    <= 1'b0;
         ovf_ff    <= 1'b0;
         rsp_valid <= 1'b0;
         p_ff      <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  rsp_out_byte   <= '0;
                  rsp_byte_valid <= 1'b0;
                  rsp_last       <= 1'b1;
                  rsp_status     <= STAT_OK;
                  rsp_length     <= '0;
                  got_ff         <= '0;
                  total_ff       <= '0;
                  flag_ff        <= 1'b0;
                  consume_ff     <= (req_mode == MODE_POP);
                  cap_ff         <= (req_capacity > CAP_W'(MAX_POP_BYTES)) ?
                                    GW'(MAX_POP_BYTES) : GW'(req_capacity);
                  p_ff           <= rp_ff;
                  if (req_mode == MODE_PUSH) begin
                     wq_ff <= wq_in;
                     wn_ff <= wn_in;
                     wi_ff <= '0;
                     fl_ff <= req_frame_last;
                     if (!pip_ff) begin
                        pip_ff <= 1'b1;
                        ovf_ff <= 1'b0;
                        fsp_ff <= wp_ff;
                        tp_ff  <= wp_ff;
                     end
                     state_ff <= ST_PUSH;
                  end else if (req_mode == MODE_POP || req_mode == MODE_PEEK) begin
                     state_ff <= ST_SKIP_RD;
                  end else begin
                     rsp_valid <= 1'b1;
                     state_ff  <= ST_RESP;
                  end
               end
            end
            // one tentative write per cycle
            ST_PUSH: begin
               if (!ovf_ff) begin
                  if (nxt(tp_ff) == rp_ff) begin
                     ovf_ff <= 1'b1;
                  end else begin
                     tp_ff <= nxt(tp_ff);
                  end
               end
               wi_ff <= wi_ff + 3'd1;
               if (wi_ff + 3'd1 == wn_ff) begin
                  state_ff <= ST_PFIN;
               end
            end
            // commit or roll back at the frame end
            ST_PFIN: begin
               if (fl_ff) begin
                  if (ovf_ff) begin
                     tp_ff      <= fsp_ff;
                     rsp_status <= STAT_FULL;
                  end else begin
                     wp_ff <= tp_ff;
                  end
                  pip_ff <= 1'b0;
                  ovf_ff <= 1'b0;
               end
               rsp_valid <= 1'b1;
               state_ff  <= ST_RESP;
            end
            // hunt for the start marker
            ST_SKIP_RD: begin
               if (p_ff == wp_ff) begin
                  st_ff <= STAT_NOFRAME;
                  if (consume_ff) begin
                     rp_ff <= wp_ff;
                  end
                  state_ff <= ST_DONE;
               end else begin
                  state_ff <= ST_SKIP_CHK;
               end
            end
            ST_SKIP_CHK: begin
               if (ring_q_ff == MK_START) begin
                  start_ff <= p_ff;
                  state_ff <= ST_BODY_RD;
               end else begin
                  state_ff <= ST_SKIP_RD;
               end
               p_ff <= nxt(p_ff);
            end
            // walk the frame body
            ST_BODY_RD: begin
               if (p_ff == wp_ff) begin
                  st_ff  <= STAT_CORRUPT;
                  got_ff <= '0;
                  if (consume_ff) begin
                     rp_ff <= nxt(start_ff);
                  end
                  state_ff <= ST_DONE;
               end else begin
                  state_ff <= ST_BODY_CHK;
               end
            end
            ST_BODY_CHK: begin
               if (body_data) begin
                  if (buf_we) begin
                     got_ff <= got_ff + 1'b1;
                  end
                  if (total_ff != LEN_SAT) begin
                     total_ff <= total_ff + 1'b1;
                  end
                  flag_ff  <= 1'b0;
                  p_ff     <= nxt(p_ff);
                  state_ff <= ST_BODY_RD;
               end else if (ring_q_ff == MK_END) begin
                  st_ff <= STAT_OK;
                  if (consume_ff) begin
                     rp_ff <= nxt(p_ff);
                  end
                  state_ff <= ST_DONE;
               end else begin
                  flag_ff  <= 1'b1;
                  p_ff     <= nxt(p_ff);
                  state_ff <= ST_BODY_RD;
               end
            end
            ST_DONE: begin
               k_ff <= '0;
               if (consume_ff && st_ff == STAT_OK && got_ff != '0) begin
                  state_ff <= ST_EMIT_RD;
               end else begin
                  rsp_status <= st_ff;
                  rsp_length <= (!consume_ff && st_ff == STAT_OK) ? total_ff : '0;
                  rsp_valid  <= 1'b1;
                  state_ff   <= ST_RESP;
               end
            end
            // deliver buffered bytes
            ST_EMIT_RD: begin
               state_ff <= ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
               rsp_out_byte   <= buf_q_ff;
               rsp_byte_valid <= 1'b1;
               rsp_last       <= (k_ff + 1'b1 == got_ff);
               rsp_status     <= STAT_OK;
               rsp_length     <= LEN_W'(got_ff);
               rsp_valid      <= 1'b1;
               state_ff       <= ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT: begin
               if (!rsp_stall) begin
                  rsp_valid <= 1'b0;
                  if (rsp_last) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     k_ff     <= k_ff + 1'b1;
                     state_ff <= ST_EMIT_RD;
                  end
               end
            end
            ST_RESP: begin
               if (!rsp_stall) begin
                  rsp_valid <= 1'b0;
                  state_ff  <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule
